// ===== rtl/nlse_pkg.sv =====
package nlse_pkg;

	localparam int MASK_BITS  = 16;
	localparam int MIN_WORDS  = 3;
	localparam int SSRC_WORDS = 2;
	localparam int POS_W      = $clog2(MIN_WORDS + 1);

	localparam logic [15:0] CAP_RESET = 16'd64;

	localparam logic KIND_ENTRY   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_SHORT = 2'd1;
	localparam logic [1:0] STATUS_SAT   = 2'd2;

	localparam logic [2:0] OP_FETCH     = 3'd0;
	localparam logic [2:0] OP_NOP       = 3'd1;
	localparam logic [2:0] OP_ENTRY_ID  = 3'd2;
	localparam logic [2:0] OP_ENTRY_BIT = 3'd3;
	localparam logic [2:0] OP_SUMMARY   = 3'd4;

	localparam logic [2:0] COND_NEVER      = 3'd0;
	localparam logic [2:0] COND_ALWAYS     = 3'd1;
	localparam logic [2:0] COND_NO_LIST    = 3'd2;
	localparam logic [2:0] COND_MASK_EMPTY = 3'd3;
	localparam logic [2:0] COND_MASK_MORE  = 3'd4;
	localparam logic [2:0] COND_NOT_LAST   = 3'd5;

	localparam int STEP_W   = 3;
	localparam int PROG_LEN = 6;

	localparam logic [STEP_W-1:0] STEP_FETCH    = 3'd0;
	localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd1;
	localparam logic [STEP_W-1:0] STEP_ID       = 3'd2;
	localparam logic [STEP_W-1:0] STEP_BIT      = 3'd3;
	localparam logic [STEP_W-1:0] STEP_CHECK    = 3'd4;
	localparam logic [STEP_W-1:0] STEP_SUMMARY  = 3'd5;

	typedef struct packed {
		logic [2:0]        op;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		ctrl_word_t word;
		logic       go;
	} seq_ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic no_list;
		logic mask_empty;
		logic mask_more;
		logic last;
	} seq_flags_t;

	localparam ctrl_word_t PROGRAM [PROG_LEN] = '{
		'{OP_FETCH,     COND_NEVER,      STEP_FETCH},
		'{OP_NOP,       COND_NO_LIST,    STEP_CHECK},
		'{OP_ENTRY_ID,  COND_MASK_EMPTY, STEP_CHECK},
		'{OP_ENTRY_BIT, COND_MASK_MORE,  STEP_BIT},
		'{OP_NOP,       COND_NOT_LAST,   STEP_FETCH},
		'{OP_SUMMARY,   COND_ALWAYS,     STEP_FETCH}
	};

endpackage

// ===== rtl/nlse_seq.sv =====
module nlse_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  nlse_pkg::seq_flags_t flags,
	output nlse_pkg::seq_ctrl_t  ctrl
);

	logic [nlse_pkg::STEP_W-1:0] step_q;
	nlse_pkg::ctrl_word_t        word;
	logic                        hold;
	logic                        taken;

	assign word = nlse_pkg::PROGRAM[step_q];

	always_comb begin
		case (word.op)
			nlse_pkg::OP_FETCH:     hold = !flags.in_valid;
			nlse_pkg::OP_ENTRY_ID,
			nlse_pkg::OP_ENTRY_BIT,
			nlse_pkg::OP_SUMMARY:   hold = !flags.out_free;
			default:                hold = 1'b0;
		endcase
	end

	always_comb begin
		case (word.cond)
			nlse_pkg::COND_NEVER:      taken = 1'b0;
			nlse_pkg::COND_ALWAYS:     taken = 1'b1;
			nlse_pkg::COND_NO_LIST:    taken = flags.no_list;
			nlse_pkg::COND_MASK_EMPTY: taken = flags.mask_empty;
			nlse_pkg::COND_MASK_MORE:  taken = flags.mask_more;
			nlse_pkg::COND_NOT_LAST:   taken = !flags.last;
			default:                   taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= nlse_pkg::STEP_FETCH;
		end else if (!hold) begin
			if (taken) begin
				step_q <= word.target;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign ctrl.word = word;
	assign ctrl.go   = !hold;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= nlse_pkg::STEP_W'(nlse_pkg::PROG_LEN - 1))
		else $error("Step counter left the program.");

	a_fetch_wait: assert property (@(posedge clk) disable iff (!arst_n)
		word.op == nlse_pkg::OP_FETCH && !flags.in_valid |=> $stable(step_q))
		else $error("Sequencer left fetch without a transfer.");

	a_summary_return: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.go && word.op == nlse_pkg::OP_SUMMARY |=> step_q == nlse_pkg::STEP_FETCH)
		else $error("Summary did not return to fetch.");

endmodule

// ===== rtl/nack_lost_sequence_expander_top.sv =====
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   payload_word, last_word
// result    out        out_valid / out_stall result_kind .. last_result
// config    in         cfg_valid / cfg_ready cfg_data (list capacity)
//
// A word passes through the control program steps fetch, dispatch, entry and check, plus
// one mask-bit step per mask bit up to the highest set bit, and a summary step on the last word.
// An SSRC word skips the entry and mask-bit steps; a new word is taken only at fetch.
// Every entry, mask-bit and summary step waits while the output register is full and stalled.
// Reset returns the capacity to 64, clears the held SSRCs and counters and starts at fetch.
module nack_lost_sequence_expander_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] payload_word,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [15:0] lost_sequence,
	output logic [15:0] list_index,
	output logic        fits_list,
	output logic [31:0] sender_ssrc,
	output logic [31:0] media_ssrc,
	output logic [15:0] total_count,
	output logic [1:0]  status,
	output logic        last_result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	nlse_pkg::seq_flags_t flags;
	nlse_pkg::seq_ctrl_t  ctrl;

	logic [15:0]                    cap_q;
	logic [nlse_pkg::POS_W-1:0]     pos_q;
	logic [31:0]                    sender_q;
	logic [31:0]                    media_q;
	logic [15:0]                    count_q;
	logic                           sat_q;
	logic                           out_valid_q;
	logic [nlse_pkg::MASK_BITS-1:0] mask_q;
	logic [15:0]                    seq_q;
	logic                           last_q;
	logic                           list_q;

	logic        kind_q;
	logic [15:0] lost_q;
	logic [15:0] index_q;
	logic        fits_q;
	logic [31:0] out_sender_q;
	logic [31:0] out_media_q;
	logic [15:0] total_q;
	logic [1:0]  status_q;
	logic        last_res_q;

	logic        in_fire;
	logic        out_free;
	logic        is_id;
	logic        is_bit;
	logic        is_sum;
	logic        emit;
	logic        entry_emit;
	logic        count_full;
	logic [15:0] entry_seq;
	logic        entry_last;
	logic [1:0]  sum_status;

	nlse_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	assign in_stall  = ctrl.word.op != nlse_pkg::OP_FETCH;
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign flags.in_valid   = in_valid;
	assign flags.out_free   = out_free;
	assign flags.no_list    = !list_q;
	assign flags.mask_empty = mask_q == '0;
	assign flags.mask_more  = (mask_q >> 1) != '0;
	assign flags.last       = last_q;

	assign is_id      = ctrl.go && ctrl.word.op == nlse_pkg::OP_ENTRY_ID;
	assign is_bit     = ctrl.go && ctrl.word.op == nlse_pkg::OP_ENTRY_BIT;
	assign is_sum     = ctrl.go && ctrl.word.op == nlse_pkg::OP_SUMMARY;
	assign entry_emit = is_id || (is_bit && mask_q[0]);
	assign emit       = entry_emit || is_sum;
	assign count_full = count_q == '1;
	assign entry_seq  = is_id ? seq_q : seq_q + 16'd1;
	assign entry_last = !last_q && (is_id ? (mask_q == '0) : ((mask_q >> 1) == '0));

	always_comb begin
		if (pos_q < nlse_pkg::POS_W'(nlse_pkg::MIN_WORDS)) begin
			sum_status = nlse_pkg::STATUS_SHORT;
		end else if (sat_q) begin
			sum_status = nlse_pkg::STATUS_SAT;
		end else begin
			sum_status = nlse_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= nlse_pkg::CAP_RESET;
			pos_q       <= '0;
			sender_q    <= '0;
			media_q     <= '0;
			count_q     <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (in_fire) begin
				if (pos_q < nlse_pkg::POS_W'(nlse_pkg::MIN_WORDS)) begin
					pos_q <= pos_q + 1'b1;
				end
				if (pos_q == nlse_pkg::POS_W'(0)) begin
					sender_q <= payload_word;
				end
				if (pos_q == nlse_pkg::POS_W'(1)) begin
					media_q <= payload_word;
				end
			end
			if (entry_emit) begin
				if (count_full) begin
					sat_q <= 1'b1;
				end else begin
					count_q <= count_q + 16'd1;
				end
			end
			if (is_sum) begin
				pos_q   <= '0;
				count_q <= '0;
				sat_q   <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mask_q <= payload_word[nlse_pkg::MASK_BITS-1:0];
			seq_q  <= payload_word[31:16];
			last_q <= last_word;
			list_q <= pos_q >= nlse_pkg::POS_W'(nlse_pkg::SSRC_WORDS);
		end
		if (is_bit) begin
			mask_q <= mask_q >> 1;
			seq_q  <= seq_q + 16'd1;
		end
		if (entry_emit) begin
			kind_q       <= nlse_pkg::KIND_ENTRY;
			lost_q       <= entry_seq;
			index_q      <= count_q;
			fits_q       <= count_q < cap_q;
			out_sender_q <= sender_q;
			out_media_q  <= media_q;
			total_q      <= count_full ? count_q : count_q + 16'd1;
			status_q     <= nlse_pkg::STATUS_OK;
			last_res_q   <= entry_last;
		end else if (is_sum) begin
			kind_q       <= nlse_pkg::KIND_SUMMARY;
			lost_q       <= '0;
			index_q      <= '0;
			fits_q       <= 1'b0;
			out_sender_q <= sender_q;
			out_media_q  <= media_q;
			total_q      <= count_q;
			status_q     <= sum_status;
			last_res_q   <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign lost_sequence = lost_q;
	assign list_index    = index_q;
	assign fits_list     = fits_q;
	assign sender_ssrc   = out_sender_q;
	assign media_ssrc    = out_media_q;
	assign total_count   = total_q;
	assign status        = status_q;
	assign last_result   = last_res_q;

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == nlse_pkg::KIND_SUMMARY |-> last_res_q)
		else $error("Summary not marked as the final result.");

	a_entry_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == nlse_pkg::KIND_ENTRY |-> fits_q == (index_q < cap_q))
		else $error("Entry fit flag disagrees with the capacity.");

	a_sat_count: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> count_full)
		else $error("Saturation flagged below the count limit.");

	a_busy_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> in_stall)
		else $error("Input taken while the previous word is still in work.");

endmodule

// ===== dv/tb_nack_lost_sequence_expander_top.sv =====
module tb_nack_lost_sequence_expander_top;

	localparam int SETTLE_CYCLES = 32;
	localparam int STALL_LIMIT   = 5000;
	localparam int ITEM_TARGET   = 150;

	typedef struct {
		logic        kind;
		logic [15:0] seq;
		logic [15:0] index;
		logic        fits;
		logic [31:0] sender;
		logic [31:0] media;
		logic [15:0] total;
		logic [1:0]  status;
		logic        last;
	} lost_result_t;

	class nack_scoreboard;
		logic [15:0]                capacity;
		logic [nlse_pkg::POS_W-1:0] word_pos;
		logic [31:0]                sender_held;
		logic [31:0]                media_held;
		logic [15:0]                entry_count;
		logic                       saturated;
		lost_result_t               expected_q[$];
		int                         mismatches;

		function new();
			capacity = nlse_pkg::CAP_RESET;
			word_pos = '0;
			sender_held = '0;
			media_held = '0;
			entry_count = '0;
			saturated = 1'b0;
			mismatches = 0;
		endfunction

		function void push_entry(logic [15:0] seq);
			lost_result_t r;
			r.kind = nlse_pkg::KIND_ENTRY;
			r.seq = seq;
			r.index = entry_count;
			if (entry_count == 16'hFFFF) begin
				saturated = 1'b1;
			end else begin
				entry_count++;
			end
			r.fits = r.index < capacity;
			r.sender = sender_held;
			r.media = media_held;
			r.total = entry_count;
			r.status = nlse_pkg::STATUS_OK;
			r.last = 1'b0;
			expected_q.push_back(r);
		endfunction

		// Works out every result that one accepted payload word causes.
		function void note_word(logic [31:0] w, logic l);
			int start_size;
			logic [15:0] id;
			lost_result_t r;
			start_size = expected_q.size();
			if (word_pos == 0) begin
				sender_held = w;
			end else if (word_pos == 1) begin
				media_held = w;
			end else begin
				id = w[31:16];
				push_entry(id);
				for (int j = 0; j < nlse_pkg::MASK_BITS && j < 16; j++) begin
					if (w[j]) begin
						push_entry(id + 16'(j + 1));
					end
				end
			end
			if (word_pos < nlse_pkg::MIN_WORDS) begin
				word_pos++;
			end
			if (l) begin
				r.kind = nlse_pkg::KIND_SUMMARY;
				r.seq = '0;
				r.index = '0;
				r.fits = 1'b0;
				r.sender = sender_held;
				r.media = media_held;
				r.total = entry_count;
				if (word_pos < nlse_pkg::MIN_WORDS) begin
					r.status = nlse_pkg::STATUS_SHORT;
				end else if (saturated) begin
					r.status = nlse_pkg::STATUS_SAT;
				end else begin
					r.status = nlse_pkg::STATUS_OK;
				end
				r.last = 1'b0;
				expected_q.push_back(r);
				word_pos = '0;
				entry_count = '0;
				saturated = 1'b0;
			end
			if (expected_q.size() > start_size) begin
				expected_q[expected_q.size() - 1].last = 1'b1;
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(lost_result_t got);
			lost_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				$display("%0t: result expected none, actual kind %0d sequence %0h",
					$time, got.kind, got.seq);
				return;
			end
			want = expected_q.pop_front();
			compare_field("result_kind", want.kind, got.kind);
			compare_field("lost_sequence", want.seq, got.seq);
			compare_field("list_index", want.index, got.index);
			compare_field("fits_list", want.fits, got.fits);
			compare_field("sender_ssrc", want.sender, got.sender);
			compare_field("media_ssrc", want.media, got.media);
			compare_field("total_count", want.total, got.total);
			compare_field("status", want.status, got.status);
			compare_field("last_result", want.last, got.last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] payload_word = '0;
	logic        last_word = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        result_kind;
	logic [15:0] lost_sequence;
	logic [15:0] list_index;
	logic        fits_list;
	logic [31:0] sender_ssrc;
	logic [31:0] media_ssrc;
	logic [15:0] total_count;
	logic [1:0]  status;
	logic        last_result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	nack_scoreboard sb = new();
	bit             steady = 1'b0;
	int             quiet_cycles = 0;
	int             items_sent = 0;
	lost_result_t   observed;

	nack_lost_sequence_expander_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.payload_word  (payload_word),
		.last_word     (last_word),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.lost_sequence (lost_sequence),
		.list_index    (list_index),
		.fits_list     (fits_list),
		.sender_ssrc   (sender_ssrc),
		.media_ssrc    (media_ssrc),
		.total_count   (total_count),
		.status        (status),
		.last_result   (last_result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 29);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			observed.kind = result_kind;
			observed.seq = lost_sequence;
			observed.index = list_index;
			observed.fits = fits_list;
			observed.sender = sender_ssrc;
			observed.media = media_ssrc;
			observed.total = total_count;
			observed.status = status;
			observed.last = last_result;
			sb.check_result(observed);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [31:0] w, input logic l);
		while (!steady && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		payload_word <= w;
		last_word <= l;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_word(w, l);
		items_sent++;
	endtask

	// The block may still be busy with a word that gives no result, hence the settling time.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		sb.capacity = value;
	endtask

	task automatic send_random_payload();
		int len;
		logic [31:0] w;
		len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
		for (int k = 0; k < len; k++) begin
			w = $urandom;
			if (k >= 2) begin
				case ($urandom_range(5))
					0: w[15:0] = 16'h0000;
					1: w[15:0] = 16'hFFFF;
					2: w[15:0] = 16'h0001 << $urandom_range(15);
					default: ;
				endcase
			end
			steady = (items_sent >= 60 && items_sent < 100);
			send_word(w, k == len - 1);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_FFFF, 1'b0);
		send_word(32'hFFFF_0001, 1'b0);
		send_word(32'hFFFF_8000, 1'b1);
		send_word(32'hA5A5_5A5A, 1'b1);
		send_word(32'h1357_9BDF, 1'b0);
		send_word(32'h2468_ACE0, 1'b1);
		send_word(32'h0F0F_F0F0, 1'b0);
		send_word(32'hF0F0_0F0F, 1'b0);
		send_word(32'h1234_0000, 1'b1);
		wait_drained();

		write_capacity(16'h0000);
		send_word(32'h0000_0001, 1'b0);
		send_word(32'h8000_0000, 1'b0);
		send_word(32'h8000_5555, 1'b1);
		wait_drained();

		write_capacity(16'h0001);
		send_word(32'hDEAD_BEEF, 1'b0);
		send_word(32'hCAFE_F00D, 1'b0);
		send_word(32'h7FFF_AAAA, 1'b0);
		send_word(32'h0010_0003, 1'b1);
		wait_drained();

		write_capacity(nlse_pkg::CAP_RESET);
		while (items_sent < ITEM_TARGET) begin
			send_random_payload();
			if ($urandom_range(3) == 0) begin
				wait_drained();
				case ($urandom_range(4))
					0: write_capacity(16'h0000);
					1: write_capacity(16'hFFFF);
					2: write_capacity(16'h0001 << $urandom_range(15));
					default: write_capacity(16'($urandom_range(16'hFFFF)));
				endcase
			end
		end
		steady = 1'b0;
		wait_drained();

		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== nack_lost_sequence_expander_top.f =====
rtl/nlse_pkg.sv
rtl/nlse_seq.sv
rtl/nack_lost_sequence_expander_top.sv
dv/tb_nack_lost_sequence_expander_top.sv
